// ===== rtl/core/http_request_line_tokenizer_core_defines.svh =====
// Assertion macros shared by the tokenizer RTL.
// Every use sits in a module with clk and arst_n in scope.
`ifndef HTTP_REQUEST_LINE_TOKENIZER_CORE_DEFINES_SVH
`define HTTP_REQUEST_LINE_TOKENIZER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check a condition in the same cycle as its trigger.
`define HRLT_ASSERT_IMPLIES(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("hrlt assertion failed");
// Check a condition in the cycle after its trigger.
`define HRLT_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("hrlt assertion failed");
`else
`define HRLT_ASSERT_IMPLIES(name, pre, post)
`define HRLT_ASSERT_NEXT(name, pre, post)
`endif

`endif

// ===== rtl/core/hrlt_pkg.sv =====
`default_nettype none

package hrlt_pkg;

	// Offsets and lengths
	localparam int MAX_REQUEST_BYTES = 8192;
	localparam int POS_W             = 13;
	localparam int POS_LIMIT_INT     = ((MAX_REQUEST_BYTES - 1) < 8191) ?
		(MAX_REQUEST_BYTES - 1) : 8191;
	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(POS_LIMIT_INT);

	// Results per input byte
	localparam int MAX_RESULTS = 3;
	localparam int CNT_W       = 2;

	// Kept method or version letters
	localparam int LETTER_W = 56;

	// Token kinds
	localparam logic [3:0] KIND_GET     = 4'd0;
	localparam logic [3:0] KIND_HEAD    = 4'd1;
	localparam logic [3:0] KIND_POST    = 4'd2;
	localparam logic [3:0] KIND_PUT     = 4'd3;
	localparam logic [3:0] KIND_DELETE  = 4'd4;
	localparam logic [3:0] KIND_CONNECT = 4'd5;
	localparam logic [3:0] KIND_OPTIONS = 4'd6;
	localparam logic [3:0] KIND_TRACE   = 4'd7;
	localparam logic [3:0] KIND_PATCH   = 4'd8;
	localparam logic [3:0] KIND_PATH    = 4'd9;
	localparam logic [3:0] KIND_QUERY   = 4'd10;
	localparam logic [3:0] KIND_VERSION = 4'd11;
	localparam logic [3:0] KIND_ERROR   = 4'd12;

	// Error kinds
	localparam logic [2:0] ERR_NONE           = 3'd0;
	localparam logic [2:0] ERR_EMPTY_METHOD   = 3'd1;
	localparam logic [2:0] ERR_UNKNOWN_METHOD = 3'd2;
	localparam logic [2:0] ERR_EMPTY_PATH     = 3'd3;
	localparam logic [2:0] ERR_BAD_VERSION    = 3'd4;

	typedef enum logic [2:0] {
		PH_METHOD    = 3'd0,
		PH_PATH_WS   = 3'd1,
		PH_PATH      = 3'd2,
		PH_QUERY     = 3'd3,
		PH_VER_WS    = 3'd4,
		PH_VER_ALPHA = 3'd5,
		PH_VER_TAIL  = 3'd6
	} phase_t;

	typedef struct packed {
		logic [3:0]       kind;
		logic [2:0]       err;
		logic [POS_W-1:0] start;
		logic [POS_W-1:0] length;
	} result_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] kind;
	} method_hit_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic logic is_num(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == " " || c == 8'h09;
	endfunction

	function automatic logic is_pchar(input logic [7:0] c);
		logic ok;
		case (c) inside
			"-", ".", "_", "~", ":", "/", "!", "$", "&", 8'h27,
			"(", ")", "*", "+", ",", ";", "=": ok = 1'b1;
			default: ok = is_letter(c) || is_num(c);
		endcase
		return ok;
	endfunction

	// Match the kept letter run against the method words
	function automatic method_hit_t method_match(input logic [LETTER_W-1:0] lt,
		input logic [3:0] lc);
		method_hit_t m;
		m.hit  = 1'b1;
		m.kind = KIND_GET;
		if (lc == 4'd3 && lt[23:0] == "GET")
			m.kind = KIND_GET;
		else if (lc == 4'd4 && lt[31:0] == "HEAD")
			m.kind = KIND_HEAD;
		else if (lc == 4'd4 && lt[31:0] == "POST")
			m.kind = KIND_POST;
		else if (lc == 4'd3 && lt[23:0] == "PUT")
			m.kind = KIND_PUT;
		else if (lc == 4'd6 && lt[47:0] == "DELETE")
			m.kind = KIND_DELETE;
		else if (lc == 4'd7 && lt[55:0] == "CONNECT")
			m.kind = KIND_CONNECT;
		else if (lc == 4'd7 && lt[55:0] == "OPTIONS")
			m.kind = KIND_OPTIONS;
		else if (lc == 4'd5 && lt[39:0] == "TRACE")
			m.kind = KIND_TRACE;
		else if (lc == 4'd5 && lt[39:0] == "PATCH")
			m.kind = KIND_PATCH;
		else
			m.hit = 1'b0;
		return m;
	endfunction

	function automatic result_t mk_result(input logic [3:0] kind, input logic [2:0] err,
		input logic [POS_W-1:0] start, input logic [POS_W-1:0] length);
		result_t r;
		r.kind   = kind;
		r.err    = err;
		r.start  = start;
		r.length = length;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hrlt_byte_if.sv =====
`default_nettype none

interface hrlt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_request;

	modport source (output valid, output data_byte, output end_of_request, input ready);
	modport sink (input valid, input data_byte, input end_of_request, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hrlt_token_if.sv =====
`default_nettype none

interface hrlt_token_if
	import hrlt_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [3:0]       token_kind;
	logic [2:0]       error_kind;
	logic [POS_W-1:0] token_start;
	logic [POS_W-1:0] token_length;
	logic             last_in_run;

	modport source (output valid, output token_kind, output error_kind, output token_start,
		output token_length, output last_in_run, input ready);
	modport sink (input valid, input token_kind, input error_kind, input token_start,
		input token_length, input last_in_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hrlt_step.sv =====
`default_nettype none
`include "http_request_line_tokenizer_core_defines.svh"

module hrlt_step
	import hrlt_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_request,
	output result_t         res [MAX_RESULTS],
	output logic [CNT_W-1:0] cnt
);

	phase_t              phase_q, ph;
	logic [POS_W-1:0]    pos_q, pos;
	logic [POS_W-1:0]    tb_q, tb;
	logic [LETTER_W-1:0] letters_q, lt;
	logic [3:0]          lc_q, lc;
	logic [1:0]          vs_q, vs;
	logic                halt_q, hlt;
	logic                done;
	logic                ends;
	method_hit_t         mm_feed, mm_flush;

	assign ends = (data_byte == 8'd0) || end_of_request;

	// Walk the phases for one byte, then close open fields at request end
	always_comb begin
		ph   = phase_q;
		pos  = pos_q;
		tb   = tb_q;
		lt   = letters_q;
		lc   = lc_q;
		vs   = vs_q;
		hlt  = halt_q;
		done = 1'b0;
		cnt  = '0;
		for (int i = 0; i < MAX_RESULTS; i++)
			res[i] = '0;
		mm_feed = method_match(letters_q, lc_q);

		if (data_byte != 8'd0 && !hlt) begin
			// method letters
			if (ph == PH_METHOD) begin
				if (is_letter(data_byte)) begin
					if (lc < 4'd7)
						lt = {lt[LETTER_W-9:0], data_byte};
					if (lc < 4'd8)
						lc = lc + 4'd1;
					if (pos < POS_LIMIT)
						pos = pos + 1'b1;
					done = 1'b1;
				end else if (lc == 4'd0) begin
					res[cnt] = mk_result(KIND_ERROR, ERR_EMPTY_METHOD, pos, '0);
					cnt = cnt + 1'b1;
					hlt = 1'b1;
					done = 1'b1;
				end else if (mm_feed.hit) begin
					res[cnt] = mk_result(mm_feed.kind, ERR_NONE, tb, pos - tb);
					cnt = cnt + 1'b1;
					ph = PH_PATH_WS;
				end else begin
					res[cnt] = mk_result(KIND_ERROR, ERR_UNKNOWN_METHOD, pos, '0);
					cnt = cnt + 1'b1;
					hlt = 1'b1;
					done = 1'b1;
				end
			end
			// blanks before the path
			if (!done && ph == PH_PATH_WS) begin
				if (is_blank(data_byte)) begin
					if (pos < POS_LIMIT)
						pos = pos + 1'b1;
					done = 1'b1;
				end else begin
					tb = pos;
					ph = PH_PATH;
				end
			end
			// path characters
			if (!done && ph == PH_PATH) begin
				if (is_pchar(data_byte)) begin
					if (pos < POS_LIMIT)
						pos = pos + 1'b1;
					done = 1'b1;
				end else if (pos == tb) begin
					res[cnt] = mk_result(KIND_ERROR, ERR_EMPTY_PATH, pos, '0);
					cnt = cnt + 1'b1;
					hlt = 1'b1;
					done = 1'b1;
				end else begin
					res[cnt] = mk_result(KIND_PATH, ERR_NONE, tb, pos - tb);
					cnt = cnt + 1'b1;
					if (data_byte == "?") begin
						if (pos < POS_LIMIT)
							pos = pos + 1'b1;
						tb = pos;
						ph = PH_QUERY;
						done = 1'b1;
					end else begin
						res[cnt] = mk_result(KIND_QUERY, ERR_NONE, pos, '0);
						cnt = cnt + 1'b1;
						ph = PH_VER_WS;
					end
				end
			end
			// query characters
			if (!done && ph == PH_QUERY) begin
				if (is_pchar(data_byte)) begin
					if (pos < POS_LIMIT)
						pos = pos + 1'b1;
					done = 1'b1;
				end else begin
					res[cnt] = mk_result(KIND_QUERY, ERR_NONE, tb, pos - tb);
					cnt = cnt + 1'b1;
					ph = PH_VER_WS;
				end
			end
			// blanks before the version
			if (!done && ph == PH_VER_WS) begin
				if (is_blank(data_byte)) begin
					if (pos < POS_LIMIT)
						pos = pos + 1'b1;
					done = 1'b1;
				end else begin
					tb = pos;
					lt = '0;
					lc = '0;
					ph = PH_VER_ALPHA;
				end
			end
			// version letters, then the slash
			if (!done && ph == PH_VER_ALPHA) begin
				if (is_letter(data_byte)) begin
					if (lc < 4'd7)
						lt = {lt[LETTER_W-9:0], data_byte};
					if (lc < 4'd8)
						lc = lc + 4'd1;
					if (pos < POS_LIMIT)
						pos = pos + 1'b1;
				end else if (lc != 4'd4 || lt[31:0] != "HTTP" || data_byte != "/") begin
					res[cnt] = mk_result(KIND_ERROR, ERR_BAD_VERSION, pos, '0);
					cnt = cnt + 1'b1;
					hlt = 1'b1;
				end else begin
					if (pos < POS_LIMIT)
						pos = pos + 1'b1;
					vs = 2'd1;
					ph = PH_VER_TAIL;
				end
				done = 1'b1;
			end
			// digit, dot, digit
			if (!done && ph == PH_VER_TAIL) begin
				if ((vs == 2'd2) ? (data_byte != ".") : !is_num(data_byte)) begin
					res[cnt] = mk_result(KIND_ERROR, ERR_BAD_VERSION, pos, '0);
					cnt = cnt + 1'b1;
					hlt = 1'b1;
				end else begin
					if (pos < POS_LIMIT)
						pos = pos + 1'b1;
					if (vs == 2'd3) begin
						res[cnt] = mk_result(KIND_VERSION, ERR_NONE, tb, pos - tb);
						cnt = cnt + 1'b1;
						hlt = 1'b1;
					end else begin
						vs = vs + 2'd1;
					end
				end
			end
		end

		// close pending fields in order at request end
		mm_flush = method_match(lt, lc);
		if (ends) begin
			if (!hlt && ph == PH_METHOD) begin
				if (lc == 4'd0) begin
					res[cnt] = mk_result(KIND_ERROR, ERR_EMPTY_METHOD, pos, '0);
					cnt = cnt + 1'b1;
					hlt = 1'b1;
				end else if (mm_flush.hit) begin
					res[cnt] = mk_result(mm_flush.kind, ERR_NONE, tb, pos - tb);
					cnt = cnt + 1'b1;
					ph = PH_PATH_WS;
				end else begin
					res[cnt] = mk_result(KIND_ERROR, ERR_UNKNOWN_METHOD, pos, '0);
					cnt = cnt + 1'b1;
					hlt = 1'b1;
				end
			end
			if (!hlt && ph == PH_PATH_WS) begin
				res[cnt] = mk_result(KIND_ERROR, ERR_EMPTY_PATH, pos, '0);
				cnt = cnt + 1'b1;
				hlt = 1'b1;
			end
			if (!hlt && ph == PH_PATH) begin
				if (pos == tb) begin
					res[cnt] = mk_result(KIND_ERROR, ERR_EMPTY_PATH, pos, '0);
					cnt = cnt + 1'b1;
				end else begin
					res[cnt] = mk_result(KIND_PATH, ERR_NONE, tb, pos - tb);
					cnt = cnt + 1'b1;
					res[cnt] = mk_result(KIND_QUERY, ERR_NONE, pos, '0);
					cnt = cnt + 1'b1;
					if (cnt != 2'd3) begin
						res[cnt] = mk_result(KIND_ERROR, ERR_BAD_VERSION, pos, '0);
						cnt = cnt + 1'b1;
					end
				end
				hlt = 1'b1;
			end
			if (!hlt && ph == PH_QUERY) begin
				res[cnt] = mk_result(KIND_QUERY, ERR_NONE, tb, pos - tb);
				cnt = cnt + 1'b1;
				if (cnt != 2'd3) begin
					res[cnt] = mk_result(KIND_ERROR, ERR_BAD_VERSION, pos, '0);
					cnt = cnt + 1'b1;
				end
				hlt = 1'b1;
			end
			if (!hlt) begin
				res[cnt] = mk_result(KIND_ERROR, ERR_BAD_VERSION, pos, '0);
				cnt = cnt + 1'b1;
				hlt = 1'b1;
			end
		end
	end

	// Hold tokenizer state; return to the start of a request at its end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_METHOD;
			pos_q     <= '0;
			tb_q      <= '0;
			letters_q <= '0;
			lc_q      <= '0;
			vs_q      <= '0;
			halt_q    <= 1'b0;
		end else if (fire) begin
			if (ends) begin
				phase_q   <= PH_METHOD;
				pos_q     <= '0;
				tb_q      <= '0;
				letters_q <= '0;
				lc_q      <= '0;
				vs_q      <= '0;
				halt_q    <= 1'b0;
			end else begin
				phase_q   <= ph;
				pos_q     <= pos;
				tb_q      <= tb;
				letters_q <= lt;
				lc_q      <= lc;
				vs_q      <= vs;
				halt_q    <= hlt;
			end
		end
	end

	`HRLT_ASSERT_NEXT(a_end_restarts, fire && ends, phase_q == PH_METHOD && pos_q == '0 && !halt_q)
	`HRLT_ASSERT_IMPLIES(a_token_inside_pos, phase_q != PH_METHOD, tb_q <= pos_q)
	`HRLT_ASSERT_NEXT(a_idle_holds_pos, !fire, $stable(pos_q))

endmodule

`default_nettype wire

// ===== rtl/core/http_request_line_tokenizer_core.sv =====
// Channel  Dir  Transaction payload
// req      in   data_byte[7:0], end_of_request
// tok      out  token_kind[3:0], error_kind[2:0], token_start[12:0], token_length[12:0],
//               last_in_run
//
// Each request byte waits in the input register, where the tokenizer
// step works it out into zero to three tokens that land together in the token register.
// The token register drains one token per cycle while tok is ready; at one token or
// fewer per byte, and with tok ready, the core takes a byte every cycle.
// arst_n clears both registers and the tokenizer state; a request starts at offset zero.
// A stalled tok channel holds the token register; one more byte is still taken into
// the input register before req.ready drops.
`default_nettype none
`include "http_request_line_tokenizer_core_defines.svh"

module http_request_line_tokenizer_core
	import hrlt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	hrlt_byte_if.sink    req,
	hrlt_token_if.source tok
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             eor_s1;
	result_t          res_q [MAX_RESULTS];
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_q;
	result_t          step_res [MAX_RESULTS];
	logic [CNT_W-1:0] step_cnt;
	logic             grp_done;
	logic             grp_free;
	logic             adv;
	result_t          cur;

	// Group drains on its last token; the input stage moves once the group is free
	assign grp_done = tok.valid && tok.ready && (idx_q == cnt_q - 1'b1);
	assign grp_free = (cnt_q == '0) || grp_done;
	assign adv      = valid_s1 && grp_free;
	assign req.ready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			byte_s1 <= req.data_byte;
			eor_s1  <= req.end_of_request;
		end
	end

	hrlt_step u_step (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (adv),
		.data_byte      (byte_s1),
		.end_of_request (eor_s1),
		.res            (step_res),
		.cnt            (step_cnt)
	);

	// Token register: load a new group, advance through it, drop it when drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (adv && step_cnt != '0) begin
			cnt_q <= step_cnt;
			idx_q <= '0;
		end else if (grp_done) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (tok.valid && tok.ready) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && step_cnt != '0)
			res_q <= step_res;
	end

	// Present the current token
	assign cur              = res_q[idx_q];
	assign tok.valid        = cnt_q != '0;
	assign tok.token_kind   = cur.kind;
	assign tok.error_kind   = cur.err;
	assign tok.token_start  = cur.start;
	assign tok.token_length = cur.length;
	assign tok.last_in_run  = idx_q == cnt_q - 1'b1;

	`HRLT_ASSERT_IMPLIES(a_idx_in_group, tok.valid, idx_q < cnt_q)
	`HRLT_ASSERT_IMPLIES(a_error_shape, tok.valid && tok.token_kind == KIND_ERROR, tok.token_length == '0 && tok.error_kind != ERR_NONE)
	`HRLT_ASSERT_IMPLIES(a_token_no_error, tok.valid && tok.token_kind != KIND_ERROR, tok.error_kind == ERR_NONE)
	`HRLT_ASSERT_NEXT(a_s1_holds, valid_s1 && !adv, valid_s1 && $stable(byte_s1) && $stable(eor_s1))
	`HRLT_ASSERT_NEXT(a_group_loads, adv && step_cnt != '0, tok.valid && idx_q == '0)

endmodule

`default_nettype wire
